[sv/rrtp_pkg.sv]
// Package for the round-robin task picker: transaction payload structs,
// command codes and slot status codes. No dependencies.
package rrtp_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ALLOC  = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_SLEEP  = 2'd3;

  localparam logic [1:0] ST_OVER    = 2'd0;
  localparam logic [1:0] ST_RUN     = 2'd1;
  localparam logic [1:0] ST_SUSPEND = 2'd2;
  localparam logic [1:0] ST_TERM    = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  slot;
    logic [1:0]  new_status;
    logic [15:0] new_sleep;
  } in_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] chosen_slot;
    logic [5:0] previous_slot;
  } out_t;

endpackage

[sv/round_robin_task_picker.sv]
// Round-robin task picker top level: slot tables, scan sequencer, output register.
// Depends on rrtp_pkg.
//
// After reset the block runs a clearing pass over every entry of its slot
// memories (slot 0 running, all others over, all sleep counts zero) and accepts
// no transaction until it ends. A status or sleep write completes at the edge
// that accepts it, its result valid on the next cycle. A tick reads one slot per
// cycle through the single read port of the slot memories and ends when it finds
// a ready slot or comes back round to the current slot; an allocate scans upward
// from slot 0 and ends at the first free slot or at the last slot. One transaction
// is worked on at a time; the next is accepted once the result register is free
// or being drained. Slot indices in results are reported modulo 64.
module round_robin_task_picker
  import rrtp_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_TICK  = 2'd2;
  localparam logic [1:0] S_ALLOC = 2'd3;

  function automatic logic [5:0] to6(input logic [SW-1:0] v);
    logic [SW+5:0] w;
    w = {6'b0, v};
    return w[5:0];
  endfunction

  logic [1:0]  st_mem [SLOTS];
  logic [15:0] sl_mem [SLOTS];

  logic [1:0]    state_q, state_d;
  logic [SW-1:0] ptr_q, ptr_d, ptr_nxt;
  logic [SW-1:0] cur_q, cur_d;
  logic          first_q, first_d;
  logic          ev_vld_q, ev_first_q;
  logic [SW-1:0] ev_idx_q;
  logic [1:0]    st_rd_q;
  logic [15:0]   sl_rd_q;
  logic          out_vld_q, out_vld_d;
  out_t          out_q, out_d;

  logic          in_acc, issue, fin, fin_ok;
  logic [SW-1:0] fin_idx, wa;
  logic          st_we, sl_we;
  logic [1:0]    st_wd;
  logic [15:0]   sl_wd;
  logic [SW+5:0] slot_w;
  logic [SW-1:0] slot_idx;
  logic          slot_ok;

  assign in_stall_o  = (state_q != S_IDLE) || (out_vld_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign ptr_nxt  = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
  assign slot_w   = {{SW{1'b0}}, in_data_i.slot};
  assign slot_idx = slot_w[SW-1:0];
  assign slot_ok  = slot_w < (SW+6)'(SLOTS);

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    first_d = first_q;
    cur_d   = cur_q;
    st_we   = 1'b0;
    sl_we   = 1'b0;
    wa      = ptr_q;
    st_wd   = ST_OVER;
    sl_wd   = '0;
    fin     = 1'b0;
    fin_ok  = 1'b0;
    fin_idx = '0;
    issue   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        st_we = 1'b1;
        sl_we = 1'b1;
        st_wd = (ptr_q == '0) ? ST_RUN : ST_OVER;
        if (ptr_q == LAST) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_nxt;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            CMD_TICK: begin
              state_d = S_TICK;
              ptr_d   = cur_q;
              first_d = 1'b1;
            end
            CMD_ALLOC: begin
              state_d = S_ALLOC;
              ptr_d   = '0;
              first_d = 1'b1;
            end
            CMD_STATUS: begin
              fin    = 1'b1;
              fin_ok = slot_ok;
              st_we  = slot_ok;
              wa     = slot_idx;
              st_wd  = in_data_i.new_status;
            end
            CMD_SLEEP: begin
              fin    = 1'b1;
              fin_ok = slot_ok;
              sl_we  = slot_ok;
              wa     = slot_idx;
              sl_wd  = in_data_i.new_sleep;
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        if (ev_vld_q) begin
          wa = ev_idx_q;
          if (ev_first_q) begin
            st_we = (st_rd_q == ST_TERM);
          end else if (ev_idx_q == cur_q) begin
            fin     = 1'b1;
            fin_idx = cur_q;
          end else begin
            st_we = (st_rd_q == ST_TERM);
            if (st_rd_q == ST_RUN) begin
              if (sl_rd_q != '0) begin
                sl_we = 1'b1;
                sl_wd = sl_rd_q - 1'b1;
              end else begin
                fin     = 1'b1;
                fin_ok  = 1'b1;
                fin_idx = ev_idx_q;
                cur_d   = ev_idx_q;
              end
            end
          end
        end
        if (fin) begin
          state_d = S_IDLE;
        end else begin
          issue   = 1'b1;
          ptr_d   = ptr_nxt;
          first_d = 1'b0;
        end
      end
      S_ALLOC: begin
        if (ev_vld_q) begin
          wa = ev_idx_q;
          if (st_rd_q == ST_OVER) begin
            st_we   = 1'b1;
            sl_we   = 1'b1;
            st_wd   = ST_SUSPEND;
            fin     = 1'b1;
            fin_ok  = 1'b1;
            fin_idx = ev_idx_q;
          end else if (ev_idx_q == LAST) begin
            fin = 1'b1;
          end
        end
        if (fin) begin
          state_d = S_IDLE;
        end else begin
          issue   = 1'b1;
          ptr_d   = ptr_nxt;
          first_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    if (fin) begin
      out_vld_d           = 1'b1;
      out_d.ok            = fin_ok;
      out_d.chosen_slot   = to6(fin_idx);
      out_d.previous_slot = to6(cur_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[wa] <= st_wd;
    end
    if (sl_we) begin
      sl_mem[wa] <= sl_wd;
    end
    st_rd_q <= st_mem[ptr_q];
    sl_rd_q <= sl_mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      ptr_q      <= '0;
      cur_q      <= '0;
      first_q    <= 1'b0;
      ev_vld_q   <= 1'b0;
      ev_first_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      cur_q      <= cur_d;
      first_q    <= first_d;
      ev_vld_q   <= issue;
      ev_first_q <= first_q;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q <= ptr_q;
    out_q    <= out_d;
  end

`ifndef ASSERT_OFF
  a_cur_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cur_q) |-> $past(state_q == S_TICK))
    else $error("current slot changed outside a tick");

  a_fin_reg_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !(out_vld_q && out_stall_i))
    else $error("result finished while result register occupied");

  a_scan_skips_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_we || sl_we) && state_q == S_TICK && !ev_first_q) |-> (wa != cur_q))
    else $error("tick scan wrote the current slot");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK || state_q == S_ALLOC) |=> !$past(in_acc))
    else $error("transaction accepted during a scan");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for round_robin_task_picker: directed and random slot commands,
// with a built-in slot table predictor, random sender bursts and receiver stalls.
// Depends on rrtp_pkg and round_robin_task_picker.
module tb_top;
  import rrtp_pkg::*;

  localparam int NUM_SLOTS   = 64;
  localparam int ITEM_TARGET = 1970;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  cmd_queue[$];
  out_t pending_picks[$];
  int   mismatch_count = 0;

  logic [1:0]  task_status[NUM_SLOTS];
  logic [15:0] task_sleep[NUM_SLOTS];
  int          running_slot;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  logic next_stall;

  round_robin_task_picker #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_t schedule_step(in_t item);
    out_t res;
    int idx;
    int n;
    res = '0;
    res.previous_slot = 6'(running_slot);
    case (item.cmd)
      CMD_TICK: begin
        if (task_status[running_slot] == ST_TERM) task_status[running_slot] = ST_OVER;
        res.chosen_slot = 6'(running_slot);
        idx = running_slot;
        for (n = 1; n < NUM_SLOTS && !res.ok; n++) begin
          idx = (idx + 1) % NUM_SLOTS;
          if (task_status[idx] == ST_TERM) task_status[idx] = ST_OVER;
          if (task_status[idx] == ST_RUN) begin
            if (task_sleep[idx] != 16'd0) begin
              task_sleep[idx] = task_sleep[idx] - 16'd1;
            end else begin
              running_slot = idx;
              res.ok = 1'b1;
              res.chosen_slot = 6'(idx);
            end
          end
        end
      end
      CMD_ALLOC: begin
        for (n = 0; n < NUM_SLOTS && !res.ok; n++) begin
          if (task_status[n] == ST_OVER) begin
            task_status[n] = ST_SUSPEND;
            task_sleep[n] = 16'd0;
            res.ok = 1'b1;
            res.chosen_slot = 6'(n);
          end
        end
      end
      CMD_STATUS: begin
        if (int'(item.slot) < NUM_SLOTS) begin
          task_status[item.slot] = item.new_status;
          res.ok = 1'b1;
        end
      end
      default: begin
        if (int'(item.slot) < NUM_SLOTS) begin
          task_sleep[item.slot] = item.new_sleep;
          res.ok = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic void queue_cmd(logic [1:0] cmd, logic [5:0] slot, logic [1:0] st,
                                    logic [15:0] sl);
    in_t item;
    item.cmd = cmd;
    item.slot = slot;
    item.new_status = st;
    item.new_sleep = sl;
    cmd_queue.push_back(item);
  endfunction

  function automatic logic [1:0] rand_cmd();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return CMD_TICK;
    else if (r < 11) return CMD_ALLOC;
    else if (r < 16) return CMD_STATUS;
    else return CMD_SLEEP;
  endfunction

  function automatic logic [5:0] rand_slot();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
  endfunction

  function automatic logic [1:0] rand_status();
    return 2'($urandom_range(ST_OVER, ST_TERM));
  endfunction

  function automatic logic [15:0] rand_sleep();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 3));
    else if (r < 8) return 16'($urandom_range(0, 40));
    else return 16'($urandom);
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = 0;
      gap_left = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        task_status[i] = ST_OVER;
        task_sleep[i] = 16'd0;
      end
      task_status[0] = ST_RUN;
      running_slot = 0;
    end else begin
      if (in_valid && !in_stall) pending_picks.push_back(schedule_step(in_data));
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= cmd_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 80)
                                                 : $urandom_range(0, 4);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_picks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ok=%0d chosen=%0d prev=%0d",
                   $time, out_data.ok, out_data.chosen_slot, out_data.previous_slot);
          mismatch_count++;
        end else begin
          out_t want;
          want = pending_picks.pop_front();
          check_field("ok", want.ok, out_data.ok);
          check_field("chosen_slot", want.chosen_slot, out_data.chosen_slot);
          check_field("previous_slot", want.previous_slot, out_data.previous_slot);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 150);
      end
      stall_left--;
      case (stall_mode)
        0: next_stall = 1'b0;
        1: next_stall = ($urandom_range(0, 3) == 0);
        2: next_stall = ($urandom_range(0, 3) != 0);
        default: next_stall = ((stall_left % 8) < 5);
      endcase
      out_stall <= next_stall;
    end
  end

  initial begin : stimulus
    int k;
    logic [5:0] s;
    // reset state, then a task that sleeps two ticks before it runs
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_ALLOC, 6'd63, ST_TERM, 16'hFFFF);
    queue_cmd(CMD_SLEEP, 6'd1, ST_OVER, 16'd2);
    queue_cmd(CMD_STATUS, 6'd1, ST_RUN, 16'd0);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    // wrap through the top slot with the largest sleep count
    queue_cmd(CMD_STATUS, 6'd63, ST_RUN, 16'd0);
    queue_cmd(CMD_SLEEP, 6'd63, ST_OVER, 16'hFFFF);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    // terminate the current slot and another one
    queue_cmd(CMD_STATUS, 6'd0, ST_TERM, 16'd0);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_STATUS, 6'd5, ST_TERM, 16'hA5A5);
    queue_cmd(CMD_SLEEP, 6'd63, ST_SUSPEND, 16'd0);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    // single runnable slot: the first tick switches to it, the second comes back round without a switch
    queue_cmd(CMD_STATUS, 6'd1, ST_SUSPEND, 16'd0);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_TICK, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_ALLOC, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_ALLOC, 6'd0, ST_OVER, 16'd0);
    queue_cmd(CMD_SLEEP, 6'd42, ST_RUN, 16'h5A5A);

    while (cmd_queue.size() < ITEM_TARGET) begin
      k = $urandom_range(0, 39);
      if (k < 16) begin
        repeat ($urandom_range(1, 20))
          queue_cmd(rand_cmd(), rand_slot(), rand_status(), rand_sleep());
      end else if (k < 30) begin
        s = rand_slot();
        queue_cmd(CMD_ALLOC, rand_slot(), rand_status(), rand_sleep());
        queue_cmd(CMD_SLEEP, s, rand_status(), rand_sleep());
        queue_cmd(CMD_STATUS, s, ST_RUN, rand_sleep());
        repeat ($urandom_range(1, 6)) queue_cmd(CMD_TICK, rand_slot(), rand_status(), rand_sleep());
      end else if (k < 38) begin
        queue_cmd(CMD_STATUS, rand_slot(), ST_TERM, rand_sleep());
        if ($urandom_range(0, 1)) queue_cmd(CMD_STATUS, rand_slot(), ST_OVER, rand_sleep());
        repeat ($urandom_range(1, 4)) queue_cmd(CMD_TICK, rand_slot(), rand_status(), rand_sleep());
      end else begin
        // occupy every slot so that allocation fails
        for (int i = 0; i < NUM_SLOTS; i++)
          queue_cmd(CMD_STATUS, 6'(i), 2'($urandom_range(ST_RUN, ST_TERM)), rand_sleep());
        queue_cmd(CMD_ALLOC, rand_slot(), rand_status(), rand_sleep());
        queue_cmd(CMD_ALLOC, rand_slot(), rand_status(), rand_sleep());
        repeat ($urandom_range(1, 5)) queue_cmd(CMD_TICK, rand_slot(), rand_status(), rand_sleep());
        repeat ($urandom_range(2, 10))
          queue_cmd(CMD_STATUS, rand_slot(), ST_OVER, rand_sleep());
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cmd_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (pending_picks.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_picks.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #24000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
